// ===== hdl/i2cram_pkg.sv =====
`default_nettype none

package i2cram_pkg;

	localparam int MAX_BURST = 16;

	localparam logic [15:0] PHASE_TICKS_RST    = 16'd50;
	localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd81;
	localparam logic [15:0] ACK_WAIT_LIMIT_RST = 16'd1000;

	// command codes carried in the operation field
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_PHASE_TICKS    = 2'd0;
	localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd1;
	localparam logic [1:0] CFG_ACK_WAIT_LIMIT = 2'd2;

	// index of a byte in a transaction: device address, register address, third byte
	localparam logic [4:0] BYTE_DEV = 5'd0;
	localparam logic [4:0] BYTE_REG = 5'd1;
	localparam logic [4:0] BYTE_RPT = 5'd2;
	localparam logic [4:0] BYTE_CNT = 5'd3;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_S_HI   = 4'd1,
		PH_S_LO   = 4'd2,
		PH_B_LO   = 4'd3,
		PH_B_HI   = 4'd4,
		PH_A_LO   = 4'd5,
		PH_A_WAIT = 4'd6,
		PH_A_END  = 4'd7,
		PH_R_LO   = 4'd8,
		PH_R_HI   = 4'd9,
		PH_K_LO   = 4'd10,
		PH_K_HI   = 4'd11,
		PH_P_LO   = 4'd12,
		PH_P_HI   = 4'd13,
		PH_P_END  = 4'd14
	} phase_t;

	typedef struct packed {
		logic       busy_res;
		logic       done_res;
		logic       ack_missing;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       sda_release;
		logic       scl_level;
	} result_t;

	typedef struct packed {
		logic       sda_in;
		logic [4:0] burst_length;
		logic [7:0] write_data;
		logic [7:0] reg_address;
		logic [1:0] operation;
	} item_t;

endpackage

`default_nettype wire

// ===== hdl/i2c_register_access_master_top.sv =====
`default_nettype none

// I2C register-access master driven by a stream of bus ticks. Each input item is either a
// tick (sample SDA, advance the bus sequencer) or a command that starts a register write
// (start, device address + W, register address, data, stop) or a burst read (start,
// device address + W, register address, repeated start, device address + R, N bytes,
// ACK on all but the last, NACK, stop). Every item yields exactly one result carrying the
// SCL/SDA levels to drive during that tick plus read-byte and status flags. Commands that
// arrive while a transaction runs are ignored. Throughput is one item per clock unless the
// result side stalls; the input and result registers lie around the single sequencer update.
// The user is to write configuration (phase length, slave address, acknowledge poll limit)
// through the cfg channel only while no transfer is in flight; the block does not check this.
module i2c_register_access_master_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// operation[1:0], reg_address[9:2], write_data[17:10], burst_length[22:18], sda_in[23]
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// scl_level[0], sda_release[1], read_byte[9:2], read_valid[10], ack_missing[11],
	// done_res[12], busy_res[13], zero fill[15:14]
	output logic [15:0]      m_tdata,
	output logic             m_tlast  // read_last
);

	// configuration
	logic [15:0] phase_ticks_q;
	logic [6:0]  device_address_q;
	logic [15:0] ack_wait_limit_q;

	// input register
	logic                 valid_s1;
	i2cram_pkg::item_t    item_s1;

	// result register
	logic                 out_valid_q;
	i2cram_pkg::result_t  out_data_q;
	logic                 out_last_q;

	// sequencer state
	i2cram_pkg::phase_t phase_q, phase_d;
	logic [3:0]  bit_cnt_q, bit_cnt_d;
	logic [4:0]  byte_cnt_q, byte_cnt_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] tick_cnt_q, tick_cnt_d;
	logic [15:0] ack_cnt_q, ack_cnt_d;
	logic [7:0]  held_reg_q, held_reg_d;
	logic [7:0]  held_data_q, held_data_d;
	logic [4:0]  held_len_q, held_len_d;
	logic        held_rd_q, held_rd_d;
	logic        timeout_q, timeout_d;

	logic                 adv;
	i2cram_pkg::result_t  res_d;
	logic                 last_d;

	logic        is_cmd;
	logic        is_last;
	logic [15:0] pt;
	logic [15:0] lim;
	logic [15:0] tick_inc;
	logic [15:0] ack_inc;
	logic [7:0]  addr_w;
	logic [4:0]  blen;
	logic [4:0]  byte_inc;
	logic [3:0]  bit_inc;
	logic [7:0]  shift_in;
	logic        scl_now;
	logic        sda_now;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {2'b00, out_data_q};
	assign m_tlast   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q    <= i2cram_pkg::PHASE_TICKS_RST;
			device_address_q <= i2cram_pkg::DEVICE_ADDRESS_RST;
			ack_wait_limit_q <= i2cram_pkg::ACK_WAIT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				i2cram_pkg::CFG_PHASE_TICKS:    phase_ticks_q    <= cfg_data;
				i2cram_pkg::CFG_DEVICE_ADDRESS: device_address_q <= cfg_data[6:0];
				i2cram_pkg::CFG_ACK_WAIT_LIMIT: ack_wait_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= i2cram_pkg::item_t'(s_tdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res_d;
			out_last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cram_pkg::PH_IDLE;
			bit_cnt_q   <= '0;
			byte_cnt_q  <= '0;
			shift_q     <= '0;
			tick_cnt_q  <= '0;
			ack_cnt_q   <= '0;
			held_reg_q  <= '0;
			held_data_q <= '0;
			held_len_q  <= '0;
			held_rd_q   <= 1'b0;
			timeout_q   <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_d;
			bit_cnt_q   <= bit_cnt_d;
			byte_cnt_q  <= byte_cnt_d;
			shift_q     <= shift_d;
			tick_cnt_q  <= tick_cnt_d;
			ack_cnt_q   <= ack_cnt_d;
			held_reg_q  <= held_reg_d;
			held_data_q <= held_data_d;
			held_len_q  <= held_len_d;
			held_rd_q   <= held_rd_d;
			timeout_q   <= timeout_d;
		end
	end

	assign is_cmd   = (item_s1.operation == i2cram_pkg::OP_WRITE) ||
	                  (item_s1.operation == i2cram_pkg::OP_READ);
	assign is_last  = ({1'b0, byte_cnt_q} + 6'd1) >= {1'b0, held_len_q};
	assign pt       = (phase_ticks_q == '0) ? 16'd1 : phase_ticks_q;
	assign lim      = (ack_wait_limit_q == '0) ? 16'd1 : ack_wait_limit_q;
	assign tick_inc = tick_cnt_q + 16'd1;
	assign ack_inc  = ack_cnt_q + 16'd1;
	assign addr_w   = {device_address_q, 1'b0};
	assign byte_inc = byte_cnt_q + 5'd1;
	assign bit_inc  = bit_cnt_q + 4'd1;
	assign shift_in = {shift_q[6:0], item_s1.sda_in};

	always_comb begin
		blen = item_s1.burst_length;
		if (blen == '0) begin
			blen = 5'd1;
		end
		if (32'(blen) > i2cram_pkg::MAX_BURST) begin
			blen = 5'(i2cram_pkg::MAX_BURST);
		end
	end

	// pin levels follow directly from the current phase
	always_comb begin
		scl_now = 1'b1;
		sda_now = 1'b1;
		unique case (phase_q)
			i2cram_pkg::PH_S_LO: sda_now = 1'b0;
			i2cram_pkg::PH_B_LO: begin
				scl_now = 1'b0;
				sda_now = shift_q[7];
			end
			i2cram_pkg::PH_B_HI: sda_now = shift_q[7];
			i2cram_pkg::PH_A_LO,
			i2cram_pkg::PH_A_END,
			i2cram_pkg::PH_R_LO: scl_now = 1'b0;
			i2cram_pkg::PH_K_LO: begin
				scl_now = 1'b0;
				sda_now = is_last;
			end
			i2cram_pkg::PH_K_HI: sda_now = is_last;
			i2cram_pkg::PH_P_LO: begin
				scl_now = 1'b0;
				sda_now = 1'b0;
			end
			i2cram_pkg::PH_P_HI: sda_now = 1'b0;
			default: ;
		endcase
	end

	always_comb begin
		phase_d     = phase_q;
		bit_cnt_d   = bit_cnt_q;
		byte_cnt_d  = byte_cnt_q;
		shift_d     = shift_q;
		tick_cnt_d  = tick_cnt_q;
		ack_cnt_d   = ack_cnt_q;
		held_reg_d  = held_reg_q;
		held_data_d = held_data_q;
		held_len_d  = held_len_q;
		held_rd_d   = held_rd_q;
		timeout_d   = timeout_q;

		res_d             = '0;
		res_d.scl_level   = scl_now;
		res_d.sda_release = sda_now;
		res_d.busy_res    = (phase_q != i2cram_pkg::PH_IDLE);
		last_d            = 1'b0;

		if (is_cmd) begin
			res_d.busy_res = 1'b1;
			if (phase_q == i2cram_pkg::PH_IDLE) begin
				held_reg_d  = item_s1.reg_address;
				held_data_d = item_s1.write_data;
				held_len_d  = blen;
				held_rd_d   = (item_s1.operation == i2cram_pkg::OP_READ);
				bit_cnt_d   = '0;
				byte_cnt_d  = '0;
				shift_d     = '0;
				ack_cnt_d   = '0;
				timeout_d   = 1'b0;
				tick_cnt_d  = '0;
				phase_d     = i2cram_pkg::PH_S_HI;
			end
		end else if (phase_q == i2cram_pkg::PH_A_WAIT) begin
			// poll until the slave pulls SDA low or the limit runs out
			if (!item_s1.sda_in) begin
				ack_cnt_d  = '0;
				tick_cnt_d = '0;
				phase_d    = i2cram_pkg::PH_A_END;
			end else begin
				ack_cnt_d = ack_inc;
				if (ack_inc >= lim) begin
					timeout_d  = 1'b1;
					ack_cnt_d  = '0;
					tick_cnt_d = '0;
					phase_d    = i2cram_pkg::PH_A_END;
				end
			end
		end else if (phase_q != i2cram_pkg::PH_IDLE) begin
			tick_cnt_d = tick_inc;
			if (tick_inc >= pt) begin
				tick_cnt_d = '0;
				unique case (phase_q)
					i2cram_pkg::PH_S_HI: phase_d = i2cram_pkg::PH_S_LO;
					i2cram_pkg::PH_S_LO: begin
						bit_cnt_d = '0;
						phase_d   = i2cram_pkg::PH_B_LO;
						if (byte_cnt_q == i2cram_pkg::BYTE_DEV) begin
							shift_d = addr_w;
						end else if (byte_cnt_q == i2cram_pkg::BYTE_REG) begin
							shift_d = held_reg_q;
						end else begin
							shift_d = held_rd_q ? (addr_w | 8'd1) : held_data_q;
						end
					end
					i2cram_pkg::PH_B_LO: phase_d = i2cram_pkg::PH_B_HI;
					i2cram_pkg::PH_B_HI: begin
						shift_d = {shift_q[6:0], 1'b0};
						if (bit_inc >= 4'd8) begin
							bit_cnt_d = '0;
							phase_d   = i2cram_pkg::PH_A_LO;
						end else begin
							bit_cnt_d = bit_inc;
							phase_d   = i2cram_pkg::PH_B_LO;
						end
					end
					i2cram_pkg::PH_A_LO: begin
						ack_cnt_d = '0;
						phase_d   = i2cram_pkg::PH_A_WAIT;
					end
					i2cram_pkg::PH_A_END: begin
						byte_cnt_d = byte_inc;
						if (!held_rd_q && byte_inc >= i2cram_pkg::BYTE_CNT) begin
							phase_d = i2cram_pkg::PH_P_LO;
						end else if (held_rd_q && byte_inc == i2cram_pkg::BYTE_RPT) begin
							// repeated start before the read address
							phase_d = i2cram_pkg::PH_S_HI;
						end else if (held_rd_q && byte_inc >= i2cram_pkg::BYTE_CNT) begin
							byte_cnt_d = '0;
							bit_cnt_d  = '0;
							shift_d    = '0;
							phase_d    = i2cram_pkg::PH_R_LO;
						end else begin
							bit_cnt_d = '0;
							phase_d   = i2cram_pkg::PH_B_LO;
							if (byte_inc == i2cram_pkg::BYTE_REG) begin
								shift_d = held_reg_q;
							end else begin
								shift_d = held_data_q;
							end
						end
					end
					i2cram_pkg::PH_R_LO: phase_d = i2cram_pkg::PH_R_HI;
					i2cram_pkg::PH_R_HI: begin
						shift_d = shift_in;
						if (bit_inc >= 4'd8) begin
							bit_cnt_d        = '0;
							res_d.read_valid = 1'b1;
							res_d.read_byte  = shift_in;
							last_d           = is_last;
							phase_d          = i2cram_pkg::PH_K_LO;
						end else begin
							bit_cnt_d = bit_inc;
							phase_d   = i2cram_pkg::PH_R_LO;
						end
					end
					i2cram_pkg::PH_K_LO: phase_d = i2cram_pkg::PH_K_HI;
					i2cram_pkg::PH_K_HI: begin
						if (is_last) begin
							phase_d = i2cram_pkg::PH_P_LO;
						end else begin
							byte_cnt_d = byte_inc;
							shift_d    = '0;
							phase_d    = i2cram_pkg::PH_R_LO;
						end
					end
					i2cram_pkg::PH_P_LO: phase_d = i2cram_pkg::PH_P_HI;
					i2cram_pkg::PH_P_HI: phase_d = i2cram_pkg::PH_P_END;
					default: begin
						res_d.done_res = 1'b1;
						phase_d        = i2cram_pkg::PH_IDLE;
					end
				endcase
			end
		end

		res_d.ack_missing = timeout_d;
	end

`ifndef SYNTHESIS
	a_read_from_rhi: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_d.read_valid |-> phase_q == i2cram_pkg::PH_R_HI)
		else $error("read byte reported outside the last read bit phase");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_d.done_res |=> phase_q == i2cram_pkg::PH_IDLE)
		else $error("sequencer not idle after stop completed");

	a_bit_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q < 4'd8)
		else $error("bit counter out of range");

	a_byte_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cram_pkg::PH_R_HI |-> byte_cnt_q < held_len_q)
		else $error("read past burst length");

	a_last_is_nack: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_d.read_valid && last_d |=> phase_q == i2cram_pkg::PH_K_LO && sda_now)
		else $error("last read byte not followed by NACK");
`endif

endmodule

`default_nettype wire

// ===== sim/i2c_register_access_master_top_tb.sv =====
`timescale 1ns / 100ps

module i2c_register_access_master_top_tb;

	// code 3 has no meaning of its own; the block takes it as a tick
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 40000;

	typedef struct packed {
		i2cram_pkg::phase_t ph;
		logic [3:0]  bit_idx;
		logic [4:0]  byte_idx;
		logic [7:0]  shreg;
		logic [15:0] tick_cnt;
		logic [15:0] ack_cnt;
		logic [7:0]  reg_addr;
		logic [7:0]  wr_data;
		logic [4:0]  len;
		logic        is_read;
		logic        timed_out;
		logic        scl;
		logic        sda;
	} bus_state_t;

	typedef struct packed {
		logic [15:0] phase_ticks;
		logic [6:0]  dev_addr;
		logic [15:0] ack_limit;
	} bus_cfg_t;

	typedef struct packed {
		logic                last;
		i2cram_pkg::result_t res;
	} bus_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = i2cram_pkg::CFG_PHASE_TICKS;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic [23:0] s_tdata = '0;
	logic        m_tready = 1'b0;
	logic        cfg_ready;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;
	logic        m_tlast;

	bus_cfg_t            cfg_now;
	bus_state_t          live_st;
	bus_state_t          plan_st;
	i2cram_pkg::item_t   bus_items_q[$];
	bus_result_t         pin_results_q[$];
	int                  planned_cnt = 0;
	int                  accepted_cnt = 0;
	int                  err_count = 0;
	int                  cycle_cnt = 0;
	logic                quiet;

	// long stretches where neither side stalls
	assign quiet = (cycle_cnt % 1000) >= 700;

	i2c_register_access_master_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic bus_state_t idle_state();
		bus_state_t st;
		st = '0;
		st.ph = i2cram_pkg::PH_IDLE;
		st.scl = 1'b1;
		st.sda = 1'b1;
		return st;
	endfunction

	function automatic logic on_last_byte(bus_state_t st);
		return (int'(st.byte_idx) + 1 >= int'(st.len));
	endfunction

	function automatic void go_phase(inout bus_state_t st, input i2cram_pkg::phase_t p);
		logic c;
		logic d;
		c = 1'b1;
		d = 1'b1;
		st.ph = p;
		st.tick_cnt = '0;
		case (p)
			i2cram_pkg::PH_S_LO: d = 1'b0;
			i2cram_pkg::PH_B_LO: begin
				c = 1'b0;
				d = st.shreg[7];
			end
			i2cram_pkg::PH_B_HI: d = st.shreg[7];
			i2cram_pkg::PH_A_LO, i2cram_pkg::PH_A_END, i2cram_pkg::PH_R_LO: c = 1'b0;
			i2cram_pkg::PH_K_LO: begin
				c = 1'b0;
				d = on_last_byte(st);
			end
			i2cram_pkg::PH_K_HI: d = on_last_byte(st);
			i2cram_pkg::PH_P_LO: begin
				c = 1'b0;
				d = 1'b0;
			end
			i2cram_pkg::PH_P_HI: d = 1'b0;
			default: ;
		endcase
		st.scl = c;
		st.sda = d;
	endfunction

	// loads the byte of the given slot into the shifter and starts its first bit
	function automatic void load_byte(inout bus_state_t st, input logic [4:0] slot);
		logic [7:0] addr_w;
		addr_w = {cfg_now.dev_addr, 1'b0};
		if (slot == i2cram_pkg::BYTE_DEV)
			st.shreg = addr_w;
		else if (slot == i2cram_pkg::BYTE_REG)
			st.shreg = st.reg_addr;
		else
			st.shreg = st.is_read ? (addr_w | 8'h01) : st.wr_data;
		st.bit_idx = '0;
		go_phase(st, i2cram_pkg::PH_B_LO);
	endfunction

	// one bus tick or command: advances the sequencer and yields the pin/status word
	function automatic void i2c_bus_step(inout bus_state_t st, input i2cram_pkg::item_t it,
			output bus_result_t r);
		logic [15:0] pt;
		logic [15:0] lim;
		int          blen;
		logic        leave;
		r = '0;
		pt = (cfg_now.phase_ticks == 16'd0) ? 16'd1 : cfg_now.phase_ticks;
		lim = (cfg_now.ack_limit == 16'd0) ? 16'd1 : cfg_now.ack_limit;
		r.res.scl_level = st.scl;
		r.res.sda_release = st.sda;
		r.res.busy_res = (st.ph != i2cram_pkg::PH_IDLE);
		if (it.operation == i2cram_pkg::OP_WRITE || it.operation == i2cram_pkg::OP_READ) begin
			if (st.ph == i2cram_pkg::PH_IDLE) begin
				blen = int'(it.burst_length);
				if (blen < 1) blen = 1;
				if (blen > i2cram_pkg::MAX_BURST) blen = i2cram_pkg::MAX_BURST;
				st.reg_addr = it.reg_address;
				st.wr_data = it.write_data;
				st.len = 5'(blen);
				st.is_read = (it.operation == i2cram_pkg::OP_READ);
				st.bit_idx = '0;
				st.byte_idx = '0;
				st.shreg = '0;
				st.ack_cnt = '0;
				st.timed_out = 1'b0;
				go_phase(st, i2cram_pkg::PH_S_HI);
			end
			r.res.scl_level = st.scl;
			r.res.sda_release = st.sda;
			r.res.busy_res = 1'b1;
		end else if (st.ph == i2cram_pkg::PH_A_WAIT) begin
			leave = 1'b0;
			if (!it.sda_in) begin
				leave = 1'b1;
			end else begin
				st.ack_cnt = st.ack_cnt + 16'd1;
				if (st.ack_cnt >= lim) begin
					st.timed_out = 1'b1;
					leave = 1'b1;
				end
			end
			if (leave) begin
				st.ack_cnt = '0;
				go_phase(st, i2cram_pkg::PH_A_END);
			end
		end else if (st.ph != i2cram_pkg::PH_IDLE) begin
			st.tick_cnt = st.tick_cnt + 16'd1;
			if (st.tick_cnt >= pt) begin
				case (st.ph)
					i2cram_pkg::PH_S_HI: go_phase(st, i2cram_pkg::PH_S_LO);
					i2cram_pkg::PH_S_LO: load_byte(st, st.byte_idx);
					i2cram_pkg::PH_B_LO: go_phase(st, i2cram_pkg::PH_B_HI);
					i2cram_pkg::PH_B_HI: begin
						st.shreg = {st.shreg[6:0], 1'b0};
						st.bit_idx = st.bit_idx + 4'd1;
						if (st.bit_idx >= 4'd8) begin
							st.bit_idx = '0;
							go_phase(st, i2cram_pkg::PH_A_LO);
						end else begin
							go_phase(st, i2cram_pkg::PH_B_LO);
						end
					end
					i2cram_pkg::PH_A_LO: begin
						st.ack_cnt = '0;
						go_phase(st, i2cram_pkg::PH_A_WAIT);
					end
					i2cram_pkg::PH_A_END: begin
						st.byte_idx = st.byte_idx + 5'd1;
						if (!st.is_read) begin
							if (st.byte_idx >= i2cram_pkg::BYTE_CNT)
								go_phase(st, i2cram_pkg::PH_P_LO);
							else
								load_byte(st, st.byte_idx);
						end else if (st.byte_idx == i2cram_pkg::BYTE_REG) begin
							load_byte(st, i2cram_pkg::BYTE_REG);
						end else if (st.byte_idx == i2cram_pkg::BYTE_RPT) begin
							// repeated start before the read address
							go_phase(st, i2cram_pkg::PH_S_HI);
						end else begin
							st.byte_idx = '0;
							st.bit_idx = '0;
							st.shreg = '0;
							go_phase(st, i2cram_pkg::PH_R_LO);
						end
					end
					i2cram_pkg::PH_R_LO: go_phase(st, i2cram_pkg::PH_R_HI);
					i2cram_pkg::PH_R_HI: begin
						st.shreg = {st.shreg[6:0], it.sda_in};
						st.bit_idx = st.bit_idx + 4'd1;
						if (st.bit_idx >= 4'd8) begin
							st.bit_idx = '0;
							r.res.read_valid = 1'b1;
							r.res.read_byte = st.shreg;
							r.last = on_last_byte(st);
							go_phase(st, i2cram_pkg::PH_K_LO);
						end else begin
							go_phase(st, i2cram_pkg::PH_R_LO);
						end
					end
					i2cram_pkg::PH_K_LO: go_phase(st, i2cram_pkg::PH_K_HI);
					i2cram_pkg::PH_K_HI: begin
						if (on_last_byte(st)) begin
							go_phase(st, i2cram_pkg::PH_P_LO);
						end else begin
							st.byte_idx = st.byte_idx + 5'd1;
							st.shreg = '0;
							go_phase(st, i2cram_pkg::PH_R_LO);
						end
					end
					i2cram_pkg::PH_P_LO: go_phase(st, i2cram_pkg::PH_P_HI);
					i2cram_pkg::PH_P_HI: go_phase(st, i2cram_pkg::PH_P_END);
					default: begin
						r.res.done_res = 1'b1;
						go_phase(st, i2cram_pkg::PH_IDLE);
					end
				endcase
			end
		end
		r.res.ack_missing = st.timed_out;
	endfunction

	function automatic i2cram_pkg::item_t rand_item(input logic [1:0] op);
		i2cram_pkg::item_t it;
		it = i2cram_pkg::item_t'(24'($urandom));
		it.operation = op;
		return it;
	endfunction

	// the planning copy of the sequencer tracks where the queued stimulus leaves the bus
	function automatic void add_item(input i2cram_pkg::item_t it);
		bus_result_t scratch;
		bus_items_q.push_back(it);
		planned_cnt++;
		i2c_bus_step(plan_st, it, scratch);
	endfunction

	function automatic void add_command(input logic [1:0] op, input logic [7:0] ra,
			input logic [7:0] wd, input logic [4:0] blen);
		i2cram_pkg::item_t it;
		it = rand_item(op);
		it.reg_address = ra;
		it.write_data = wd;
		it.burst_length = blen;
		add_item(it);
	endfunction

	function automatic void add_ticks(input int n);
		for (int i = 0; i < n; i++)
			add_item(rand_item(i2cram_pkg::OP_TICK));
	endfunction

	function automatic void drain_plan();
		while (plan_st.ph != i2cram_pkg::PH_IDLE)
			add_item(rand_item(i2cram_pkg::OP_TICK));
	endfunction

	function automatic void plan_random(input int n);
		int                r;
		i2cram_pkg::item_t it;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (plan_st.ph == i2cram_pkg::PH_IDLE) begin
				if (r < 70) begin
					it = rand_item(r[0] ? i2cram_pkg::OP_READ : i2cram_pkg::OP_WRITE);
					it.burst_length = ($urandom_range(0, 9) < 7) ?
						5'($urandom_range(1, 4)) : 5'($urandom_range(0, 31));
					add_item(it);
				end else if (r < 80) begin
					add_item(rand_item(OP_SPARE));
				end else begin
					add_item(rand_item(i2cram_pkg::OP_TICK));
				end
			end else if (r < 3) begin
				// dropped: a transaction is running
				add_item(rand_item(r[0] ? i2cram_pkg::OP_READ : i2cram_pkg::OP_WRITE));
			end else if (r < 6) begin
				add_item(rand_item(OP_SPARE));
			end else begin
				add_item(rand_item(i2cram_pkg::OP_TICK));
			end
		end
	endfunction

	task automatic note_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic cmp_field(input string name, input logic [7:0] got_v,
			input logic [7:0] want_v);
		if (got_v !== want_v)
			note_mismatch($sformatf("%s got %0h want %0h", name, got_v, want_v));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			i2cram_pkg::CFG_PHASE_TICKS:    cfg_now.phase_ticks = val;
			i2cram_pkg::CFG_DEVICE_ADDRESS: cfg_now.dev_addr = val[6:0];
			i2cram_pkg::CFG_ACK_WAIT_LIMIT: cfg_now.ack_limit = val;
			default: ;
		endcase
	endtask

	// every queued item taken and every result seen, then a short idle wait
	task automatic settle();
		while (accepted_cnt != planned_cnt || pin_results_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin : feed
		bus_result_t outcome;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				i2c_bus_step(live_st, i2cram_pkg::item_t'(s_tdata), outcome);
				pin_results_q.push_back(outcome);
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (bus_items_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 20)) begin
					s_tvalid <= 1'b1;
					s_tdata <= bus_items_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin : watch
		bus_result_t         want;
		i2cram_pkg::result_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = i2cram_pkg::result_t'(m_tdata[13:0]);
				if (pin_results_q.size() == 0) begin
					note_mismatch("result transfer with nothing expected");
				end else begin
					want = pin_results_q.pop_front();
					cmp_field("scl_level", 8'(got.scl_level), 8'(want.res.scl_level));
					cmp_field("sda_release", 8'(got.sda_release), 8'(want.res.sda_release));
					cmp_field("read_byte", got.read_byte, want.res.read_byte);
					cmp_field("read_valid", 8'(got.read_valid), 8'(want.res.read_valid));
					cmp_field("read_last", 8'(m_tlast), 8'(want.last));
					cmp_field("ack_missing", 8'(got.ack_missing), 8'(want.res.ack_missing));
					cmp_field("done_res", 8'(got.done_res), 8'(want.res.done_res));
					cmp_field("busy_res", 8'(got.busy_res), 8'(want.res.busy_res));
				end
			end
			m_tready <= quiet || ($urandom_range(0, 99) >= 20);
		end
	end

	initial begin
		int pt_set [2];
		int ack_set [2];
		pt_set = '{2, 0};
		ack_set = '{2, 0};
		cfg_now.phase_ticks = i2cram_pkg::PHASE_TICKS_RST;
		cfg_now.dev_addr = i2cram_pkg::DEVICE_ADDRESS_RST;
		cfg_now.ack_limit = i2cram_pkg::ACK_WAIT_LIMIT_RST;
		live_st = idle_state();
		plan_st = idle_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset timing and address: start condition and first bit of a write,
		// a dropped read on top
		add_item(rand_item(OP_SPARE));
		add_ticks(3);
		add_command(i2cram_pkg::OP_WRITE, 8'hA5, 8'h5A, 5'd1);
		add_command(i2cram_pkg::OP_READ, 8'h00, 8'h00, 5'd3);
		add_ticks(110);
		settle();

		// fastest timing, address 0, single-sample acknowledge window; the write runs on
		write_reg(i2cram_pkg::CFG_PHASE_TICKS, 16'd1);
		write_reg(i2cram_pkg::CFG_DEVICE_ADDRESS, 16'd0);
		write_reg(i2cram_pkg::CFG_ACK_WAIT_LIMIT, 16'd1);
		drain_plan();
		// zero length reads one byte
		add_command(i2cram_pkg::OP_READ, 8'h00, 8'h00, 5'd0);
		add_ticks(2);
		add_command(i2cram_pkg::OP_WRITE, 8'h33, 8'hCC, 5'd2);
		drain_plan();
		// above the maximum burst: saturates
		add_command(i2cram_pkg::OP_READ, 8'hFF, 8'h00, 5'd31);
		drain_plan();
		settle();

		for (int k = 0; k < 2; k++) begin
			write_reg(i2cram_pkg::CFG_PHASE_TICKS, 16'(pt_set[k]));
			write_reg(i2cram_pkg::CFG_DEVICE_ADDRESS,
				(k == 0) ? 16'd127 : 16'($urandom_range(0, 65535)));
			write_reg(i2cram_pkg::CFG_ACK_WAIT_LIMIT, 16'(ack_set[k]));
			plan_random(20);
			drain_plan();
			settle();
		end

		// slowest timing: the start condition just keeps counting
		write_reg(i2cram_pkg::CFG_PHASE_TICKS, 16'd65535);
		write_reg(i2cram_pkg::CFG_DEVICE_ADDRESS, 16'($urandom_range(0, 65535)));
		write_reg(i2cram_pkg::CFG_ACK_WAIT_LIMIT, 16'd65535);
		add_ticks(4);
		add_command(i2cram_pkg::OP_READ, 8'h5A, 8'hA5, 5'd16);
		add_ticks(60);
		settle();

		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
